### src/bhac_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the button hold and alarm control block.
// Used by bhac_hold and button_hold_and_alarm_control_core; depends on nothing.
package bhac_pkg;

	// Width of the millisecond time base and of every release deadline.
	localparam int TIME_BITS = 32;

	// Number of buttons sampled on a tick and the bit of the acknowledge button.
	localparam int NUM_BUTTONS = 3;
	localparam int ACK_BIT     = 2;

	// Configuration register indexes.
	localparam int CFG_IDX_BITS = 3;
	localparam logic [CFG_IDX_BITS-1:0] REG_DEBOUNCE_MS      = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_ACK_HOLD_MS      = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_TONE_ROLL_MS     = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_TONE_LOW_PERIOD  = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_TONE_HIGH_PERIOD = 3'd4;

	localparam int CFG_DATA_BITS = 24;

	// Reset values of the configuration registers and of the tone state.
	localparam logic [15:0] DEBOUNCE_RESET    = 16'd20;
	localparam logic [23:0] ACK_HOLD_RESET    = 24'h02BF20;
	localparam logic [7:0]  TONE_ROLL_RESET   = 8'd250;
	localparam logic [7:0]  TONE_LOW_RESET    = 8'd100;
	localparam logic [7:0]  TONE_HIGH_RESET   = 8'd200;

	// Input item codes for the mode field.
	localparam logic MODE_TICK  = 1'b0;
	localparam logic MODE_ALARM = 1'b1;

	typedef logic [TIME_BITS-1:0] time_t;

	// Hold tracking state: active-low held bits and one deadline per button.
	typedef struct packed {
		logic [NUM_BUTTONS-1:0] held_n;
		time_t [NUM_BUTTONS-1:0] deadline;
	} hold_state_t;

endpackage

### src/button_hold_and_alarm_control_core.sv
`timescale 1ns / 1ps
// Top level of the button hold and alarm control block.
// Depends on bhac_pkg and instantiates bhac_hold.
//
// Usage:
// The item channel (item_valid, item_stall) carries one item per millisecond
// tick (mode 0) or per alarm request (mode 1), together with the raw
// active-low button levels and the light switch level. Each item gives
// exactly one result on the result channel (result_valid, result_stall):
// the switch status byte, the acknowledge LED, the buzzer enable, the tone
// period and duty, and the ADC-start pulse.
// An accepted item lands in an input register; once the output register is
// free or its result is taken, the state is updated and the result is loaded
// into the output register, which raises result_valid. One item is taken in
// every cycle as long as the result side keeps up; the rate is set by the
// single update of the state registers per item.
// When the receiver stalls, the result stays in the output register and the
// input register holds its item; item_stall then rises until the result is
// taken. The configuration channel is always ready; the user must write it
// only while the block is idle, which the block itself does not enforce.
// Reset clears the time base, the holds and the buzzer, reloads the roll
// counter and tone period, and restores every configuration register.
module button_hold_and_alarm_control_core (
	input  logic                                clk,
	input  logic                                arst_n,
	// Item channel.
	input  logic                                item_valid,
	output logic                                item_stall,
	input  logic                                mode,
	input  logic [2:0]                          buttons_n,
	input  logic                                light_switch_n,
	// Result channel.
	output logic                                result_valid,
	input  logic                                result_stall,
	output logic [7:0]                          switch_status,
	output logic                                ack_led,
	output logic                                buzzer_on,
	output logic [7:0]                          tone_period,
	output logic [6:0]                          tone_duty,
	output logic                                adc_start,
	// Configuration write channel.
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [bhac_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [bhac_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

	// Configuration registers.
	logic [15:0] debounce_q;
	logic [23:0] ack_hold_q;
	logic [7:0]  roll_reg_q;
	logic [7:0]  tone_low_q;
	logic [7:0]  tone_high_q;

	// Block state.
	bhac_pkg::time_t      ms_q;
	logic [7:0]           roll_q;
	bhac_pkg::hold_state_t hold_q;
	logic                 buzzer_q;
	logic [7:0]           tone_q;

	// Input register stage.
	logic       valid_s1;
	logic       mode_s1;
	logic [2:0] buttons_n_s1;
	logic       light_n_s1;

	// Output register.
	logic       result_valid_q;
	logic [7:0] status_q;
	logic       ack_led_q;
	logic       buzzer_out_q;
	logic [7:0] tone_out_q;
	logic       adc_q;

	// Next-state values.
	logic                  adv_s1;
	bhac_pkg::time_t       ms_new;
	logic [7:0]            roll_dec;
	bhac_pkg::hold_state_t hold_tick;
	bhac_pkg::hold_state_t hold_next;
	bhac_pkg::time_t       ms_next;
	logic [7:0]            roll_next;
	logic                  buzzer_next;
	logic [7:0]            tone_next;
	logic                  adc_next;
	logic                  buzzer_after_press;
	logic [7:0]            status_next;

	// The item in the input register moves on whenever the output register
	// is empty or its result is taken in this cycle.
	assign adv_s1     = valid_s1 && (!result_valid_q || !result_stall);
	assign item_stall = valid_s1 && !adv_s1;
	assign cfg_ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q  <= bhac_pkg::DEBOUNCE_RESET;
			ack_hold_q  <= bhac_pkg::ACK_HOLD_RESET;
			roll_reg_q  <= bhac_pkg::TONE_ROLL_RESET;
			tone_low_q  <= bhac_pkg::TONE_LOW_RESET;
			tone_high_q <= bhac_pkg::TONE_HIGH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				bhac_pkg::REG_DEBOUNCE_MS:      debounce_q  <= cfg_data[15:0];
				bhac_pkg::REG_ACK_HOLD_MS:      ack_hold_q  <= cfg_data[23:0];
				bhac_pkg::REG_TONE_ROLL_MS:     roll_reg_q  <= cfg_data[7:0];
				bhac_pkg::REG_TONE_LOW_PERIOD:  tone_low_q  <= cfg_data[7:0];
				bhac_pkg::REG_TONE_HIGH_PERIOD: tone_high_q <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	// Input register: the payload needs no reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			mode_s1      <= mode;
			buttons_n_s1 <= buttons_n;
			light_n_s1   <= light_switch_n;
		end
	end

	assign ms_new   = ms_q + bhac_pkg::time_t'(1);
	assign roll_dec = roll_q - 8'd1;

	bhac_hold u_hold (
		.ms_new      (ms_new),
		.buttons_n   (buttons_n_s1),
		.debounce_ms (debounce_q),
		.ack_hold_ms (ack_hold_q),
		.cur         (hold_q),
		.nxt         (hold_tick)
	);

	// One tick advances time, holds and the roll counter; an alarm request
	// only arms the buzzer, and only outside the acknowledge window.
	always_comb begin
		ms_next     = ms_q;
		roll_next   = roll_q;
		hold_next   = hold_q;
		buzzer_next = buzzer_q;
		tone_next   = tone_q;
		adc_next    = 1'b0;
		buzzer_after_press = buzzer_q && buttons_n_s1[bhac_pkg::ACK_BIT];
		if (mode_s1 == bhac_pkg::MODE_TICK) begin
			ms_next     = ms_new;
			roll_next   = roll_dec;
			hold_next   = hold_tick;
			buzzer_next = buzzer_after_press;
			if (roll_dec == 8'd0) begin
				roll_next = roll_reg_q;
				adc_next  = 1'b1;
				if (buzzer_after_press) begin
					tone_next = (tone_q == tone_high_q) ? tone_low_q : tone_high_q;
				end
			end
		end else begin
			if (hold_q.held_n[bhac_pkg::ACK_BIT]) begin
				buzzer_next = 1'b1;
			end
		end
	end

	always_comb begin
		status_next    = 8'h00;
		status_next[7] = !hold_next.held_n[0];
		status_next[6] = !light_n_s1;
		status_next[4] = !hold_next.held_n[1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ms_q     <= '0;
			roll_q   <= bhac_pkg::TONE_ROLL_RESET;
			hold_q.held_n   <= '1;
			hold_q.deadline <= '0;
			buzzer_q <= 1'b0;
			tone_q   <= bhac_pkg::TONE_LOW_RESET;
		end else if (adv_s1) begin
			ms_q     <= ms_next;
			roll_q   <= roll_next;
			hold_q   <= hold_next;
			buzzer_q <= buzzer_next;
			tone_q   <= tone_next;
		end
	end

	// Output register: valid clears when the result is taken with nothing behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (adv_s1) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			status_q     <= status_next;
			ack_led_q    <= !hold_next.held_n[bhac_pkg::ACK_BIT];
			buzzer_out_q <= buzzer_next;
			tone_out_q   <= tone_next;
			adc_q        <= adc_next;
		end
	end

	assign result_valid  = result_valid_q;
	assign switch_status = status_q;
	assign ack_led       = ack_led_q;
	assign buzzer_on     = buzzer_out_q;
	assign tone_period   = tone_out_q;
	assign tone_duty     = tone_out_q[7:1];
	assign adc_start     = adc_q;

	// The buzzer can only be armed outside the acknowledge window, and any
	// acknowledge press silences it, so the two are never on together.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(buzzer_on && ack_led))
		else $error("buzzer enabled inside the acknowledge window");

	// An empty output register never pushes back on the item channel.
	assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid_q |-> !item_stall)
		else $error("item channel stalled with an empty output register");

	// Time only moves on a tick item that leaves the input register.
	assert property (@(posedge clk) disable iff (!arst_n)
		!(adv_s1 && (mode_s1 == bhac_pkg::MODE_TICK)) |=> $stable(ms_q))
		else $error("millisecond count changed without a tick item");

endmodule

### src/bhac_hold.sv
`timescale 1ns / 1ps
// Next-state logic of the button holds for one millisecond tick.
// Depends on bhac_pkg for the time type and the hold state struct.
module bhac_hold (
	input  bhac_pkg::time_t                         ms_new,
	input  logic [bhac_pkg::NUM_BUTTONS-1:0]        buttons_n,
	input  logic [15:0]                             debounce_ms,
	input  logic [23:0]                             ack_hold_ms,
	input  bhac_pkg::hold_state_t                   cur,
	output bhac_pkg::hold_state_t                   nxt
);

	bhac_pkg::time_t                        debounce_ext;
	bhac_pkg::time_t                        ack_ext;
	logic [bhac_pkg::NUM_BUTTONS-1:0]       held_pressed;
	bhac_pkg::time_t [bhac_pkg::NUM_BUTTONS-1:0] dl_next;

	assign debounce_ext = bhac_pkg::time_t'(debounce_ms);
	assign ack_ext      = bhac_pkg::time_t'(ack_hold_ms);

	// A press clears the held bit and restarts the deadline from the new time.
	always_comb begin
		for (int b = 0; b < bhac_pkg::NUM_BUTTONS; b++) begin
			if (!buttons_n[b]) begin
				held_pressed[b] = 1'b0;
				dl_next[b] = ms_new + ((b == bhac_pkg::ACK_BIT) ? ack_ext : debounce_ext);
			end else begin
				held_pressed[b] = cur.held_n[b];
				dl_next[b] = cur.deadline[b];
			end
		end
	end

	// Releases are only checked while something is held; the compare is unsigned.
	always_comb begin
		nxt.deadline = dl_next;
		nxt.held_n   = held_pressed;
		if (held_pressed != '1) begin
			for (int b = 0; b < bhac_pkg::NUM_BUTTONS; b++) begin
				if (ms_new >= dl_next[b]) begin
					nxt.held_n[b] = 1'b1;
				end
			end
		end
	end

endmodule

### bench/button_hold_and_alarm_control_core_test.sv
`timescale 1ns / 1ps
// Self-checking bench for button_hold_and_alarm_control_core.
// Depends on bhac_pkg and the core; drives ticks, alarms and register writes
// and checks every result against an in-bench model of the panel logic.
module button_hold_and_alarm_control_core_test;

	// Button bit positions within buttons_n, besides ACK_BIT from the package.
	localparam int TRAP_BIT    = 0;
	localparam int SHUTTER_BIT = 1;

	// Bits of the switch status byte.
	localparam logic [7:0] STATUS_TRAP    = 8'h80;
	localparam logic [7:0] STATUS_LIGHT   = 8'h40;
	localparam logic [7:0] STATUS_SHUTTER = 8'h10;

	// Register indexes that the block does not decode and must ignore.
	localparam logic [bhac_pkg::CFG_IDX_BITS-1:0] REG_UNUSED_LOW  = 3'd5;
	localparam logic [bhac_pkg::CFG_IDX_BITS-1:0] REG_UNUSED_HIGH = 3'd7;

	typedef struct packed {
		logic       mode;
		logic [2:0] buttons_n;
		logic       light_switch_n;
	} panel_item_t;

	typedef struct packed {
		logic [7:0] switch_status;
		logic       ack_led;
		logic       buzzer_on;
		logic [7:0] tone_period;
		logic [6:0] tone_duty;
		logic       adc_start;
	} panel_result_t;

	logic clk;
	logic arst_n = 1'b0;

	// Every input of the block starts at a known value.
	logic                               item_valid     = 1'b0;
	logic                               mode           = bhac_pkg::MODE_TICK;
	logic [2:0]                         buttons_n      = 3'b111;
	logic                               light_switch_n = 1'b1;
	logic                               result_stall   = 1'b0;
	logic                               cfg_valid      = 1'b0;
	logic [bhac_pkg::CFG_IDX_BITS-1:0]  cfg_index      = '0;
	logic [bhac_pkg::CFG_DATA_BITS-1:0] cfg_data       = '0;

	logic       item_stall;
	logic       result_valid;
	logic [7:0] switch_status;
	logic       ack_led;
	logic       buzzer_on;
	logic [7:0] tone_period;
	logic [6:0] tone_duty;
	logic       adc_start;
	logic       cfg_ready;

	button_hold_and_alarm_control_core u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.item_valid     (item_valid),
		.item_stall     (item_stall),
		.mode           (mode),
		.buttons_n      (buttons_n),
		.light_switch_n (light_switch_n),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.switch_status  (switch_status),
		.ack_led        (ack_led),
		.buzzer_on      (buzzer_on),
		.tone_period    (tone_period),
		.tone_duty      (tone_duty),
		.adc_start      (adc_start),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	// Model copy of the configuration registers, starting at their reset values.
	logic [15:0] debounce_ms  = bhac_pkg::DEBOUNCE_RESET;
	logic [23:0] ack_hold_ms  = bhac_pkg::ACK_HOLD_RESET;
	logic [7:0]  tone_roll_ms = bhac_pkg::TONE_ROLL_RESET;
	logic [7:0]  tone_low     = bhac_pkg::TONE_LOW_RESET;
	logic [7:0]  tone_high    = bhac_pkg::TONE_HIGH_RESET;

	// Model copy of the panel state, starting at its reset values.
	bhac_pkg::time_t                  now_ms     = '0;
	logic [7:0]                       roll_left  = bhac_pkg::TONE_ROLL_RESET;
	logic [bhac_pkg::NUM_BUTTONS-1:0] held_n     = '1;
	bhac_pkg::time_t                  release_at [bhac_pkg::NUM_BUTTONS] = '{default: '0};
	logic                             buzzer_set = 1'b0;
	logic [7:0]                       tone_now   = bhac_pkg::TONE_LOW_RESET;

	// Items waiting to be offered, and the results that accepted items must give.
	panel_item_t   pending_items [$];
	panel_result_t panel_expected [$];
	panel_item_t   offered_item;

	int unsigned items_queued   = 0;
	int unsigned items_taken    = 0;
	int unsigned mismatch_count = 0;

	// Set during a phase in which neither side idles or stalls at random.
	bit quiet_phase = 1'b0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Prints one line per failure and counts it.
	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		mismatch_count++;
		$display("mismatch on %s: got %0h, expected %0h", what, got, want);
	endtask

	// Advances the model by one item and gives the result it must produce.
	// A tick moves time and the roll counter, latches presses with a fresh
	// release deadline and then releases every hold whose deadline has come.
	// An alarm request only sets the buzzer, and only outside the acknowledge
	// window.
	task automatic step_panel_model(input panel_item_t it, output panel_result_t res);
		bhac_pkg::time_t hold;
		int              b;
		res = '0;
		if (it.mode == bhac_pkg::MODE_TICK) begin
			now_ms    = now_ms + bhac_pkg::time_t'(1);
			roll_left = roll_left - 8'd1;
			for (b = 0; b < bhac_pkg::NUM_BUTTONS; b++) begin
				if (!it.buttons_n[b]) begin
					hold = (b == bhac_pkg::ACK_BIT) ? bhac_pkg::time_t'(ack_hold_ms)
							: bhac_pkg::time_t'(debounce_ms);
					held_n[b]     = 1'b0;
					release_at[b] = now_ms + hold;
					if (b == bhac_pkg::ACK_BIT) begin
						buzzer_set = 1'b0;
					end
				end
			end
			// Releases are only looked at while something is held; the
			// compare is unsigned, so a wrapped deadline releases at once.
			if (held_n != '1) begin
				for (b = 0; b < bhac_pkg::NUM_BUTTONS; b++) begin
					if (now_ms >= release_at[b]) begin
						held_n[b] = 1'b1;
					end
				end
			end
			// The reload value is read only here, so a new roll period takes
			// effect at the next expiry. A zero period wraps to 256 ticks.
			if (roll_left == 8'd0) begin
				roll_left     = tone_roll_ms;
				res.adc_start = 1'b1;
				if (buzzer_set) begin
					tone_now = (tone_now == tone_high) ? tone_low : tone_high;
				end
			end
		end else if (held_n[bhac_pkg::ACK_BIT]) begin
			buzzer_set = 1'b1;
		end
		if (!held_n[TRAP_BIT]) begin
			res.switch_status |= STATUS_TRAP;
		end
		if (!held_n[SHUTTER_BIT]) begin
			res.switch_status |= STATUS_SHUTTER;
		end
		if (!it.light_switch_n) begin
			res.switch_status |= STATUS_LIGHT;
		end
		res.ack_led     = !held_n[bhac_pkg::ACK_BIT];
		res.buzzer_on   = buzzer_set;
		res.tone_period = tone_now;
		res.tone_duty   = tone_now[7:1];
	endtask

	// Gaps between items: mostly none, often short, now and then long.
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (quiet_phase || r < 60) begin
			return 0;
		end else if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 30);
	endfunction

	// Driver. It owns the item channel; a new item is only presented once the
	// previous one has been taken, so valid never reacts to the stall.
	int unsigned gap_left = 0;

	always @(posedge clk) begin
		panel_result_t want;
		if (arst_n) begin
			if (item_valid && !item_stall) begin
				step_panel_model(offered_item, want);
				panel_expected.push_back(want);
				items_taken++;
				gap_left = pick_gap();
			end
			if (item_valid && item_stall) begin
				// The stalled item stays on the port unchanged.
			end else if (gap_left > 0) begin
				gap_left--;
				item_valid <= 1'b0;
			end else if (pending_items.size() > 0) begin
				offered_item = pending_items.pop_front();
				item_valid     <= 1'b1;
				mode           <= offered_item.mode;
				buttons_n      <= offered_item.buttons_n;
				light_switch_n <= offered_item.light_switch_n;
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// Now and then the receiver holds off for a long stretch. The first one
	// comes early in the first phase, while plenty of items are still queued,
	// so the sender keeps offering and the block fills up and stalls its input.
	int unsigned pressure_cycle = 0;
	logic        rx_hold_off    = 1'b0;

	always @(posedge clk) begin
		if (arst_n) begin
			pressure_cycle <= pressure_cycle + 1;
			rx_hold_off    <= ((pressure_cycle % 1500) >= 40)
					&& ((pressure_cycle % 1500) < 100);
		end
	end

	// Monitor. It checks each taken result against the oldest expected one
	// and drives the result stall in runs of random length.
	int unsigned rx_run_left  = 0;
	logic        rx_run_stall = 1'b0;

	always @(posedge clk) begin
		panel_result_t want;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (panel_expected.size() == 0) begin
					report_mismatch("result with no item outstanding", 0, 0);
				end else begin
					want = panel_expected.pop_front();
					if (switch_status !== want.switch_status)
						report_mismatch("switch_status", switch_status, want.switch_status);
					if (ack_led !== want.ack_led)
						report_mismatch("ack_led", ack_led, want.ack_led);
					if (buzzer_on !== want.buzzer_on)
						report_mismatch("buzzer_on", buzzer_on, want.buzzer_on);
					if (tone_period !== want.tone_period)
						report_mismatch("tone_period", tone_period, want.tone_period);
					if (tone_duty !== want.tone_duty)
						report_mismatch("tone_duty", tone_duty, want.tone_duty);
					if (adc_start !== want.adc_start)
						report_mismatch("adc_start", adc_start, want.adc_start);
				end
			end
			if (rx_run_left > 0) begin
				rx_run_left--;
			end else if (quiet_phase) begin
				rx_run_stall = 1'b0;
				rx_run_left  = $urandom_range(5, 20);
			end else if ($urandom_range(0, 99) < 65) begin
				rx_run_stall = 1'b0;
				rx_run_left  = $urandom_range(1, 6);
			end else begin
				rx_run_stall = 1'b1;
				rx_run_left  = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3)
						: $urandom_range(10, 40);
			end
			result_stall <= rx_hold_off || rx_run_stall;
		end
	end

	task automatic push_item(input logic m, input logic [2:0] btn, input logic light);
		pending_items.push_back('{mode: m, buttons_n: btn, light_switch_n: light});
		items_queued++;
	endtask

	// Random items are mostly ticks with nothing pressed, so that holds run
	// out and releases are seen; presses of the acknowledge button are kept
	// rare so that alarms can get the buzzer going and the tone can toggle.
	task automatic push_random_items(input int count);
		panel_item_t it;
		repeat (count) begin
			it.mode      = ($urandom_range(0, 99) < 14) ? bhac_pkg::MODE_ALARM
					: bhac_pkg::MODE_TICK;
			it.buttons_n = 3'b111;
			if ($urandom_range(0, 99) < 35) begin
				it.buttons_n[TRAP_BIT]    = 1'($urandom_range(0, 1));
				it.buttons_n[SHUTTER_BIT] = 1'($urandom_range(0, 1));
				it.buttons_n[bhac_pkg::ACK_BIT] = ($urandom_range(0, 99) < 12) ? 1'b0 : 1'b1;
			end
			it.light_switch_n = 1'($urandom_range(0, 1));
			pending_items.push_back(it);
			items_queued++;
		end
	endtask

	// Returns at a rising edge once every queued item has been taken and
	// every result has come back.
	task automatic wait_for_drain();
		while (items_taken != items_queued || panel_expected.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Writes one register; called at a rising edge and returns at the edge of
	// the write. Valid is left high so that writes can follow back to back.
	task automatic cfg_write(input logic [bhac_pkg::CFG_IDX_BITS-1:0] idx,
			input logic [bhac_pkg::CFG_DATA_BITS-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			bhac_pkg::REG_DEBOUNCE_MS:      debounce_ms  = data[15:0];
			bhac_pkg::REG_ACK_HOLD_MS:      ack_hold_ms  = data[23:0];
			bhac_pkg::REG_TONE_ROLL_MS:     tone_roll_ms = data[7:0];
			bhac_pkg::REG_TONE_LOW_PERIOD:  tone_low     = data[7:0];
			bhac_pkg::REG_TONE_HIGH_PERIOD: tone_high    = data[7:0];
			default: ;
		endcase
	endtask

	task automatic set_panel_config(input logic [15:0] debounce, input logic [23:0] ack,
			input logic [7:0] roll, input logic [7:0] low, input logic [7:0] high);
		cfg_write(bhac_pkg::REG_DEBOUNCE_MS, 24'(debounce));
		cfg_write(bhac_pkg::REG_ACK_HOLD_MS, ack);
		cfg_write(bhac_pkg::REG_TONE_ROLL_MS, 24'(roll));
		cfg_write(bhac_pkg::REG_TONE_LOW_PERIOD, 24'(low));
		cfg_write(bhac_pkg::REG_TONE_HIGH_PERIOD, 24'(high));
		cfg_valid <= 1'b0;
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at reset settings. Nothing pressed, then the light
		// switch, each button alone and all together, then idle ticks that end
		// before the debounce holds run out.
		push_item(bhac_pkg::MODE_TICK, 3'b111, 1'b1);
		push_item(bhac_pkg::MODE_TICK, 3'b111, 1'b0);
		push_item(bhac_pkg::MODE_TICK, 3'b110, 1'b1);
		push_item(bhac_pkg::MODE_TICK, 3'b101, 1'b0);
		push_item(bhac_pkg::MODE_TICK, 3'b011, 1'b1);
		push_item(bhac_pkg::MODE_TICK, 3'b000, 1'b0);
		// The acknowledge window is open, so this alarm must be ignored.
		push_item(bhac_pkg::MODE_ALARM, 3'b111, 1'b1);
		repeat (12) push_item(bhac_pkg::MODE_TICK, 3'b111, 1'b1);
		push_item(bhac_pkg::MODE_ALARM, 3'b000, 1'b0);
		push_item(bhac_pkg::MODE_TICK, 3'b011, 1'b1);
		push_item(bhac_pkg::MODE_ALARM, 3'b111, 1'b1);
		push_item(bhac_pkg::MODE_TICK, 3'b111, 1'b0);
		push_random_items(160);
		wait_for_drain();

		// Every hold time zero, so presses release on the same tick, and the
		// shortest roll period with the tone at its lowest and highest codes.
		// The roll counter is not reloaded by this write.
		set_panel_config(16'd0, 24'd0, 8'd1, 8'd0, 8'd255);
		// An alarm with nothing held, then ticks that toggle the tone.
		push_item(bhac_pkg::MODE_TICK, 3'b011, 1'b1);
		push_item(bhac_pkg::MODE_ALARM, 3'b111, 1'b1);
		push_random_items(150);
		wait_for_drain();

		// Largest hold times and roll period; unknown indexes are ignored.
		cfg_write(REG_UNUSED_LOW, 24'hFFFFFF);
		cfg_write(REG_UNUSED_HIGH, 24'h000001);
		set_panel_config(16'hFFFF, 24'hFFFFFF, 8'd255, 8'd255, 8'd0);
		push_random_items(150);
		wait_for_drain();

		// A zero roll period makes expiry come every 256 ticks. This phase
		// runs without random gaps or stalls on either side.
		quiet_phase = 1'b1;
		set_panel_config(16'd5, 24'd12, 8'd0, 8'd100, 8'd200);
		push_random_items(160);
		wait_for_drain();
		quiet_phase = 1'b0;

		// Equal tone periods: the toggle always lands on the same value.
		set_panel_config(16'd3, 24'd40, 8'd7, 8'd17, 8'd17);
		push_random_items(160);
		wait_for_drain();

		set_panel_config(16'd1, 24'd2, 8'd3, 8'h55, 8'hAA);
		push_random_items(170);
		wait_for_drain();

		repeat (8) @(posedge clk);
		if (panel_expected.size() != 0) begin
			report_mismatch("results still outstanding", panel_expected.size(), 0);
		end
		if (mismatch_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	initial begin
		#1000000;
		$display("FAILURE");
		$finish;
	end

endmodule

### filelist.f
src/bhac_pkg.sv
src/bhac_hold.sv
src/button_hold_and_alarm_control_core.sv
bench/button_hold_and_alarm_control_core_test.sv
